FILE: rtl/ole_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ole_pkg: shared types and constants for the ordered list engine
// Command and status codes, widths and sequencer states.
// ----------------------------------------------------------------------------
package ole_pkg;

  localparam int Capacity  = 16;
  localparam int DataWidth = 32;
  localparam int AddrWidth = $clog2(Capacity);
  localparam int CountWidth = $clog2(Capacity + 1);

  typedef enum logic [3:0] {
    CMD_INS_FIRST = 4'd0,
    CMD_INS_LAST  = 4'd1,
    CMD_INS_AT    = 4'd2,
    CMD_RM_FIRST  = 4'd3,
    CMD_RM_LAST   = 4'd4,
    CMD_RM_VALUE  = 4'd5,
    CMD_RM_AT     = 4'd6,
    CMD_REVERSE   = 4'd7,
    CMD_SEARCH    = 4'd8,
    CMD_KEEP_EVEN = 4'd9,
    CMD_CLEAR     = 4'd10
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_RANGE     = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_SHR_RD,
    S_SHR_WR,
    S_INS_WR,
    S_SHL_RD,
    S_SHL_WR,
    S_REV_RD,
    S_REV_RD2,
    S_REV_WR,
    S_REV_WR2,
    S_KEEP_RD,
    S_KEEP_CHK,
    S_DONE
  } state_t;

endpackage

FILE: rtl/ole_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ole_ram: generic single-port RAM
// One write or one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
module ole_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: rtl/ordered_list_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_engine: ordered list of signed words with a command sequencer
// Entries live in a single-port RAM; shifts, scans, reversal and pruning
// walk through it one access per cycle.
// ----------------------------------------------------------------------------
// Throughput: one command at a time; a new command is taken once the result
//   transfer leaves the output register.
// Reset: rst (synchronous) empties the list and drops any pending result;
//   the RAM holds no reset and needs no clearing pass.
module ordered_list_engine
  import ole_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [3:0]                   command,
  input  logic signed [31:0]           value,
  input  logic [4:0]                   position,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [2:0]                   status,
  output logic [3:0]                   found_index,
  output logic signed [31:0]           sum,
  output logic [4:0]                   count,
  output logic                         is_empty
);

  state_t state, state_next;

  // Command registers.
  logic [3:0]            cmd;
  logic [DataWidth-1:0]  val;
  logic [CountWidth-1:0] pos;
  logic [CountWidth-1:0] len;

  // Walk indices: i reads/walks, k is the insert or compaction write point, j mirror.
  logic [CountWidth-1:0] i, k, j;
  logic [DataWidth-1:0]  hold;
  logic [31:0]           acc;
  logic [2:0]            st;
  logic [3:0]            fidx;

  // RAM port.
  logic                  we;
  logic [AddrWidth-1:0]  addr;
  logic [DataWidth-1:0]  wdata, rdata;

  ole_ram #(.Width(DataWidth), .Depth(Capacity)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  assign in_stall = (state != S_IDLE);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) state_next = S_DECIDE;
      S_DECIDE: begin
        priority case (cmd)
          CMD_INS_FIRST, CMD_INS_LAST, CMD_INS_AT: begin
            if ((cmd == CMD_INS_AT && pos > len) || len >= CountWidth'(Capacity))
              state_next = S_DONE;
            else if (i == k) state_next = S_INS_WR;
            else state_next = S_SHR_RD;
          end
          CMD_RM_FIRST, CMD_RM_LAST, CMD_RM_AT: begin
            if (len == '0 || (cmd == CMD_RM_AT && pos >= len)) state_next = S_DONE;
            else if (i + 1'b1 >= len) state_next = S_DONE;
            else state_next = S_SHL_RD;
          end
          CMD_RM_VALUE, CMD_SEARCH:
            state_next = (len == '0) ? S_DONE : S_SCAN_RD;
          CMD_REVERSE:
            state_next = (len < CountWidth'(2)) ? S_DONE : S_REV_RD;
          CMD_KEEP_EVEN:
            state_next = (len == '0) ? S_DONE : S_KEEP_RD;
          default: state_next = S_DONE;
        endcase
      end
      S_SCAN_RD:  state_next = S_SCAN_CHK;
      S_SCAN_CHK: begin
        if (rdata == val) begin
          if (cmd == CMD_RM_VALUE && i + 1'b1 < len) state_next = S_SHL_RD;
          else state_next = S_DONE;
        end else if (i + 1'b1 >= len) state_next = S_DONE;
        else state_next = S_SCAN_RD;
      end
      S_SHR_RD: state_next = S_SHR_WR;
      S_SHR_WR: state_next = (i - 1'b1 == k) ? S_INS_WR : S_SHR_RD;
      S_INS_WR: state_next = S_DONE;
      S_SHL_RD: state_next = S_SHL_WR;
      S_SHL_WR: state_next = (i + 1'b1 >= len) ? S_DONE : S_SHL_RD;
      S_REV_RD:  state_next = S_REV_RD2;
      S_REV_RD2: state_next = S_REV_WR;
      S_REV_WR:  state_next = S_REV_WR2;
      S_REV_WR2: state_next = (i + 1'b1 < j - 1'b1) ? S_REV_RD : S_DONE;
      S_KEEP_RD: state_next = S_KEEP_CHK;
      S_KEEP_CHK: state_next = (i + 1'b1 >= len) ? S_DONE : S_KEEP_RD;
      S_DONE: if (!out_stall) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // RAM access for each state.
  always_comb begin
    we    = 1'b0;
    addr  = i[AddrWidth-1:0];
    wdata = rdata;
    unique case (state)
      S_SHR_RD:  addr = AddrWidth'(i - 1'b1);
      S_SHR_WR:  we = 1'b1;
      S_INS_WR: begin
        we = 1'b1; addr = k[AddrWidth-1:0]; wdata = val;
      end
      S_SHL_RD:  addr = AddrWidth'(i + 1'b1);
      S_SHL_WR:  we = 1'b1;
      S_REV_RD2: addr = j[AddrWidth-1:0];
      S_REV_WR:  begin
        we = 1'b1; addr = i[AddrWidth-1:0];
      end
      S_REV_WR2: begin
        we = 1'b1; addr = j[AddrWidth-1:0]; wdata = hold;
      end
      S_KEEP_CHK: begin
        we = (i != '0) && !rdata[0]; addr = k[AddrWidth-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      len   <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        S_IDLE: if (in_valid) begin
          cmd  <= command;
          val  <= value;
          pos  <= position;
          st   <= ST_OK;
          fidx <= '0;
          acc  <= '0;
          j    <= '0;
          // Prepare walk indices per command.
          unique case (command)
            CMD_INS_FIRST: begin i <= len; k <= '0; end
            CMD_INS_LAST:  begin i <= len; k <= len; end
            CMD_INS_AT:    begin i <= len; k <= position; end
            CMD_RM_LAST:   begin i <= len - 1'b1; k <= '0; end
            CMD_RM_AT:     begin i <= position; k <= '0; end
            CMD_REVERSE:   begin i <= '0; k <= '0; j <= len - 1'b1; end
            default:       begin i <= '0; k <= '0; end
          endcase
        end
        S_DECIDE: begin
          priority case (cmd)
            CMD_INS_FIRST, CMD_INS_LAST, CMD_INS_AT: begin
              if (cmd == CMD_INS_AT && pos > len) st <= ST_RANGE;
              else if (len >= CountWidth'(Capacity)) st <= ST_FULL;
              else len <= len + 1'b1;
            end
            CMD_RM_FIRST, CMD_RM_LAST, CMD_RM_AT: begin
              if (len == '0) st <= ST_EMPTY;
              else if (cmd == CMD_RM_AT && pos >= len) st <= ST_RANGE;
              else len <= len - 1'b1;
            end
            CMD_RM_VALUE, CMD_KEEP_EVEN: if (len == '0) st <= ST_EMPTY;
            CMD_SEARCH: if (len == '0) st <= ST_NOT_FOUND;
            CMD_CLEAR: len <= '0;
            default: ;
          endcase
        end
        S_SCAN_CHK: begin
          if (rdata == val) begin
            fidx <= (cmd == CMD_SEARCH) ? i[3:0] : 4'd0;
            if (cmd == CMD_RM_VALUE) len <= len - 1'b1;
          end else if (i + 1'b1 >= len) begin
            st <= ST_NOT_FOUND;
          end else begin
            i <= i + 1'b1;
          end
        end
        S_SHR_WR: i <= i - 1'b1;
        // len already dropped by one, so the last move lands at len-1.
        S_SHL_WR: i <= i + 1'b1;
        S_REV_RD2: hold <= rdata;
        S_REV_WR2: begin
          i <= i + 1'b1;
          j <= j - 1'b1;
        end
        S_KEEP_CHK: begin
          if (i == '0) begin
            acc <= 32'(signed'(rdata));
            k   <= CountWidth'(1);
          end else if (!rdata[0]) begin
            acc <= acc + 32'(signed'(rdata));
            k   <= k + 1'b1;
          end
          if (i + 1'b1 >= len) begin
            len <= (i == '0 || !rdata[0]) ? k + 1'b1 : k;
          end
          i <= i + 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign out_valid   = (state == S_DONE);
  assign status      = st;
  assign found_index = fidx;
  assign sum         = acc;
  assign count       = len;
  assign is_empty    = (len == '0);

endmodule

FILE: sim/tb_ordered_list_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ordered_list_engine: self-checking bench for the ordered list engine
// A behavioral copy of the list predicts each result; random gaps and stalls
// on both sides, long receiver hold-offs and drain pauses stress the handshake.
// ----------------------------------------------------------------------------

import ole_pkg::*;

typedef struct packed {
  logic [2:0]  status;
  logic [3:0]  found_index;
  logic [31:0] sum;
  logic [4:0]  count;
  logic        is_empty;
} list_result_t;

class list_scoreboard;
  logic [31:0]  words[Capacity];
  int           length;
  list_result_t pending[$];
  int           errors;
  int           checked;

  function new();
    length = 0;
    errors = 0;
    checked = 0;
  endfunction

  // Apply one accepted command to the shadow list and queue its result.
  function void note_command(logic [3:0] cmd, logic [31:0] val, logic [4:0] pos);
    list_result_t r;
    int i;
    int k;
    int at;
    logic [31:0] t;
    r = '0;
    r.status = ST_OK;
    case (cmd)
      CMD_INS_FIRST, CMD_INS_LAST, CMD_INS_AT: begin
        if (cmd == CMD_INS_AT && pos > length) begin
          r.status = ST_RANGE;
        end else if (length >= Capacity) begin
          r.status = ST_FULL;
        end else begin
          at = (cmd == CMD_INS_FIRST) ? 0 : (cmd == CMD_INS_LAST) ? length : pos;
          for (i = length; i > at; i--) words[i] = words[i-1];
          words[at] = val;
          length++;
        end
      end
      CMD_RM_FIRST, CMD_RM_LAST, CMD_RM_AT, CMD_RM_VALUE: begin
        at = -1;
        if (length == 0) r.status = ST_EMPTY;
        else if (cmd == CMD_RM_FIRST) at = 0;
        else if (cmd == CMD_RM_LAST) at = length - 1;
        else if (cmd == CMD_RM_AT) begin
          if (pos >= length) r.status = ST_RANGE;
          else at = pos;
        end else begin
          for (i = 0; i < length && words[i] != val; i++) ;
          if (i == length) r.status = ST_NOT_FOUND;
          else at = i;
        end
        if (at >= 0) begin
          for (i = at; i + 1 < length; i++) words[i] = words[i+1];
          length--;
        end
      end
      CMD_REVERSE: begin
        for (i = 0; i < length / 2; i++) begin
          t = words[i];
          words[i] = words[length-1-i];
          words[length-1-i] = t;
        end
      end
      CMD_SEARCH: begin
        for (i = 0; i < length && words[i] != val; i++) ;
        if (i == length) r.status = ST_NOT_FOUND;
        else r.found_index = i[3:0];
      end
      CMD_KEEP_EVEN: begin
        if (length == 0) begin
          r.status = ST_EMPTY;
        end else begin
          // The head always stays; later odd entries drop out.
          r.sum = words[0];
          k = 1;
          for (i = 1; i < length; i++) begin
            if (!words[i][0]) begin
              r.sum = r.sum + words[i];
              words[k] = words[i];
              k++;
            end
          end
          length = k;
        end
      end
      CMD_CLEAR: length = 0;
      default: ;
    endcase
    r.count = length[4:0];
    r.is_empty = (length == 0);
    pending.push_back(r);
  endfunction

  function void check_result(list_result_t got);
    list_result_t exp;
    checked++;
    if (pending.size() == 0) begin
      report("unexpected result", 0, 0);
      return;
    end
    exp = pending.pop_front();
    if (got.status !== exp.status) report("status", got.status, exp.status);
    if (got.found_index !== exp.found_index)
      report("found_index", got.found_index, exp.found_index);
    if (got.sum !== exp.sum) report("sum", got.sum, exp.sum);
    if (got.count !== exp.count) report("count", got.count, exp.count);
    if (got.is_empty !== exp.is_empty) report("is_empty", got.is_empty, exp.is_empty);
  endfunction

  function void report(string what, logic [31:0] got, logic [31:0] exp);
    errors++;
    $display("MISMATCH %s: got 0x%0h expected 0x%0h (result %0d)", what, got, exp, checked);
  endfunction
endclass

module tb_ordered_list_engine;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [3:0]  command;
  logic [31:0] value;
  logic [4:0]  position;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  status;
  logic [3:0]  found_index;
  logic [31:0] sum;
  logic [4:0]  count;
  logic        is_empty;

  list_scoreboard board;
  int  sent;
  bit  hold_receiver;   // request a long receiver hold-off

  ordered_list_engine dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .command(command), .value(value), .position(position),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .found_index(found_index), .sum(sum),
    .count(count), .is_empty(is_empty)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one command and hold it until the block takes the transfer.
  task automatic send(logic [3:0] cmd, logic [31:0] val, logic [4:0] pos);
    in_valid <= 1'b1;
    command  <= cmd;
    value    <= val;
    position <= pos;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_command(cmd, val, pos);
    sent++;
  endtask

  task automatic idle_gap(int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      command  <= $urandom;
      value    <= $urandom;
      position <= $urandom;
      repeat (n) @(posedge clk);
    end
  endtask

  // Drop valid and wait for every queued result to come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  // Pick a value: extremes, small values, ones already in the list, or random words.
  function automatic logic [31:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4 && board.length > 0) return board.words[$urandom_range(0, board.length - 1)];
    if (r == 4) return 32'h8000_0000;
    if (r == 5) return 32'h7fff_ffff;
    if (r == 6) return $urandom_range(0, 7);
    return $urandom;
  endfunction

  // Receiver: random stalls, plus a long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_receiver) begin
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < 30);
    end
  end

  // Check every result transfer.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      board.check_result('{status, found_index, sum, count, is_empty});
  end

  initial begin
    int i;
    int n;
    int c;
    board = new();
    sent = 0;
    hold_receiver = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    command = '0;
    value = '0;
    position = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty-list cases, fill to full, every command, extremes.
    send(CMD_RM_FIRST, 0, 0);
    send(CMD_RM_LAST, 0, 0);
    send(CMD_RM_VALUE, 5, 0);
    send(CMD_RM_AT, 0, 0);
    send(CMD_KEEP_EVEN, 0, 0);
    send(CMD_SEARCH, 0, 0);
    send(CMD_REVERSE, 0, 0);
    send(CMD_INS_AT, 1, 1);
    send(CMD_INS_FIRST, 32'h8000_0000, 0);
    send(CMD_REVERSE, 0, 0);
    send(CMD_INS_LAST, 32'h7fff_ffff, 0);
    send(CMD_INS_AT, 32'hffff_ffff, 1);
    for (i = 0; i < 13; i++) send(CMD_INS_LAST, $urandom, 0);
    send(CMD_INS_AT, 3, 16);
    send(CMD_INS_FIRST, 4, 0);
    send(CMD_INS_AT, 4, 17);
    send(CMD_INS_AT, 4, 31);
    send(CMD_SEARCH, 32'h7fff_ffff, 0);
    send(CMD_RM_AT, 0, 16);
    send(CMD_RM_AT, 0, 15);
    send(CMD_KEEP_EVEN, 0, 0);
    send(CMD_RM_VALUE, 32'h8000_0000, 0);
    send(4'd11, 0, 0);
    send(4'd15, 32'hffff_ffff, 5'h1f);
    send(CMD_CLEAR, 0, 0);
    drain();

    // Random: build lists up and exercise every command on them, plus undefined codes.
    for (n = 0; n < 400; n++) begin
      if (n == 120) begin
        // Hold the receiver off while the sender keeps offering.
        hold_receiver = 1;
        fork
          begin
            repeat (150) @(posedge clk);
            hold_receiver = 0;
          end
        join_none
      end
      if (n % 97 == 96) drain();
      c = $urandom_range(0, 99);
      if (c < 35) c = $urandom_range(CMD_INS_FIRST, CMD_INS_AT);
      else if (c < 60) c = $urandom_range(CMD_RM_FIRST, CMD_RM_AT);
      else if (c < 90) c = $urandom_range(CMD_REVERSE, CMD_KEEP_EVEN);
      else if (c < 95) c = CMD_CLEAR;
      else c = $urandom_range(11, 15);
      send(c[3:0], pick_value(),
           ($urandom_range(0, 9) == 0) ? 5'($urandom) : 5'($urandom_range(0, board.length)));
      idle_gap(gap_len());
    end
    drain();
    repeat (50) @(posedge clk);
    $display("Ran %0d commands across all list operations, %0d results checked.",
             sent, board.checked);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Timeout after %0d commands.", sent);
    $display("*** FAILED ***");
    $finish;
  end

endmodule

FILE: files.f
rtl/ole_pkg.sv
rtl/ole_ram.sv
rtl/ordered_list_engine.sv
sim/tb_ordered_list_engine.sv
